// ----- rtl/bba_pkg.sv -----
package bba_pkg;

	localparam int unsigned MinOrderDef    = 5;
	localparam int unsigned MaxOrderDef    = 16;
	localparam int unsigned HeaderBytesDef = 16;
	localparam logic [31:0] HeapBaseReset  = 32'hD000_0000;

	localparam logic [2:0] ST_OK     = 3'd0;
	localparam logic [2:0] ST_OOM    = 3'd1;
	localparam logic [2:0] ST_ZERO   = 3'd2;
	localparam logic [2:0] ST_NULL   = 3'd3;
	localparam logic [2:0] ST_BADHDR = 3'd4;
	localparam logic [2:0] ST_DOUBLE = 3'd5;

	localparam logic KIND_ALLOC = 1'b0;
	localparam logic KIND_FREE  = 1'b1;

	localparam logic [0:0] REG_HEAP_BASE = 1'b0;

	typedef enum logic [15:0] {
		S_IDLE   = 16'h0001,
		S_ASIZE  = 16'h0002,
		S_ASCAN  = 16'h0004,
		S_AUNL   = 16'h0008,
		S_AUNL2  = 16'h0010,
		S_ASPLIT = 16'h0020,
		S_APUSH  = 16'h0040,
		S_AFIN   = 16'h0080,
		S_FCHK   = 16'h0100,
		S_FHDR   = 16'h0200,
		S_FBUD   = 16'h0400,
		S_FBUDW  = 16'h0800,
		S_FUNL   = 16'h1000,
		S_FUNL2  = 16'h2000,
		S_FPUSH  = 16'h4000,
		S_DONE   = 16'h8000
	} state_t;

endpackage

// ----- rtl/bba_ram.sv -----
module bba_ram #(
	parameter int unsigned Width = 8,
	parameter int unsigned Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ----- rtl/buddy_block_allocator.sv -----
// Buddy allocator over a 2^MaxOrder byte heap seen as 2^MinOrder byte slots.
// Request channel: kind, request_size, free_address are taken on a clock edge
// with start high and busy low. busy stays high until the result is shown.
// Result channel: block_address and status are valid for one cycle while done
// is high; the receiver cannot stall, so nothing ever waits on the output.
// Allocate: header added, order rounded up one order a cycle, free lists
// scanned one order a cycle, the found block unlinked (S_AUNL, S_FUNL2,
// S_AUNL2) and split one level at a time (S_ASPLIT, S_APUSH), pushing
// upper halves. Free: header checks in S_FCHK and S_FHDR, then merged
// with free equal-order buddies (slot XOR) one level at a time (S_FBUD,
// S_FBUDW, S_FUNL2, S_FUNL), and the result pushed. One item at a time:
// a new request is taken only once busy is low; the header, next and
// prev tables are one-read one-write RAMs and set the pace.
// Reset: a clearing pass walks the header RAM, one slot a cycle, with busy
// high; then slot 0 holds one free block of the top order. heap_base resets
// to 0xD0000000 and is written on the APB port; writing it only moves the
// address mapping.
module buddy_block_allocator import bba_pkg::*; #(
	parameter int unsigned MinOrder    = MinOrderDef,
	parameter int unsigned MaxOrder    = MaxOrderDef,
	parameter int unsigned HeaderBytes = HeaderBytesDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        start,
	output logic        busy,
	input  logic        kind,
	input  logic [31:0] request_size,
	input  logic [31:0] free_address,
	output logic        done,
	output logic [31:0] block_address,
	output logic [2:0]  status
);
	localparam int unsigned SW   = MaxOrder - MinOrder;     // slot index width
	localparam int unsigned NS   = 1 << SW;
	localparam int unsigned LW   = SW + 1;                  // link incl. none
	localparam int unsigned NOR  = SW + 1;
	localparam int unsigned OW   = $clog2(NOR);
	localparam logic [LW-1:0] NONE = LW'(NS);
	localparam logic [32:0] HEAPB = 33'(64'd1 << MaxOrder);

	logic [31:0] heap_base_q;
	assign pready = 1'b1;
	assign prdata = (paddr[1:0] == {REG_HEAP_BASE, 1'b0}) ? heap_base_q : 32'd0;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heap_base_q <= HeapBaseReset;
		end else if (psel && penable && pwrite && paddr[1:0] == {REG_HEAP_BASE, 1'b0}) begin
			heap_base_q <= pwdata;
		end
	end

	// header: [6] valid [5] free [4:0] order
	logic          h_we, n_we, p_we;
	logic [SW-1:0] h_wa, h_ra, n_wa, n_ra, p_wa, p_ra;
	logic [6:0]    h_wd, h_rd;
	logic [LW-1:0] n_wd, n_rd, p_wd, p_rd;

	bba_ram #(.Width(7), .Depth(NS)) u_hdr (.clk, .we(h_we), .waddr(h_wa),
		.wdata(h_wd), .raddr(h_ra), .rdata(h_rd));
	bba_ram #(.Width(LW), .Depth(NS)) u_next (.clk, .we(n_we), .waddr(n_wa),
		.wdata(n_wd), .raddr(n_ra), .rdata(n_rd));
	bba_ram #(.Width(LW), .Depth(NS)) u_prev (.clk, .we(p_we), .waddr(p_wa),
		.wdata(p_wd), .raddr(p_ra), .rdata(p_rd));

	logic [LW-1:0] head_q [NOR];
	state_t        state_q;
	logic          clr_q;
	logic [LW-1:0] clr_cnt_q;
	logic          kind_q;
	logic [32:0]   total_q;
	logic [31:0]   fa_q;
	logic [OW-1:0] want_q, lvl_q;    // levels relative to MinOrder
	logic [SW-1:0] idx_q, bud_q;
	logic [LW-1:0] nx_q, pv_q;
	logic [31:0]   addr_q;
	logic [2:0]    st_q;
	logic          done_q;

	assign busy = clr_q || state_q != S_IDLE;
	assign done = done_q;
	assign block_address = addr_q;
	assign status = st_q;

	logic [SW-1:0] bit_l;
	assign bit_l = SW'(1) << lvl_q;
	logic [SW-1:0] bit_m;
	assign bit_m = SW'(1) << (lvl_q - 1'b1);
	logic [31:0] off_w;
	assign off_w = fa_q - 32'(HeaderBytes) - heap_base_q;

	always_comb begin
		h_we = 1'b0; h_wa = idx_q; h_wd = '0; h_ra = idx_q;
		n_we = 1'b0; n_wa = idx_q; n_wd = '0; n_ra = idx_q;
		p_we = 1'b0; p_wa = idx_q; p_wd = '0; p_ra = idx_q;
		if (clr_q) begin
			h_we = 1'b1;
			h_wa = clr_cnt_q[SW-1:0];
			h_wd = (clr_cnt_q == '0) ? {2'b11, 5'(MaxOrder)} : 7'd0;
			n_we = clr_cnt_q == '0;
			n_wa = '0;
			n_wd = NONE;
			p_we = clr_cnt_q == '0;
			p_wa = '0;
			p_wd = NONE;
		end else begin
			case (state_q)
				S_AUNL: begin
					n_ra = idx_q; p_ra = idx_q;
				end
				S_AUNL2, S_FUNL: begin
					// p<-n, n<-p around the removed node
					n_we = !pv_q[SW]; n_wa = pv_q[SW-1:0]; n_wd = nx_q;
					p_we = !nx_q[SW]; p_wa = nx_q[SW-1:0]; p_wd = pv_q;
					if (state_q == S_FUNL) begin
						h_we = 1'b1; h_wa = (bud_q < idx_q) ? idx_q : bud_q; h_wd = 7'd0;
					end
				end
				S_ASPLIT: begin
					// upper half goes on the next lower list
					h_we = 1'b1; h_wa = idx_q | bit_m;
					h_wd = {2'b11, 5'(lvl_q - 1'b1) + 5'(MinOrder)};
					n_we = 1'b1; n_wa = idx_q | bit_m; n_wd = head_q[lvl_q - 1'b1];
					p_we = 1'b1; p_wa = idx_q | bit_m; p_wd = NONE;
				end
				S_APUSH: begin
					p_we = !nx_q[SW]; p_wa = nx_q[SW-1:0];
					p_wd = {1'b0, idx_q | bit_l};
				end
				S_FPUSH: begin
					h_we = 1'b1; h_wa = idx_q;
					h_wd = {2'b11, 5'(lvl_q) + 5'(MinOrder)};
					n_we = 1'b1; n_wa = idx_q; n_wd = nx_q;
					p_we = !nx_q[SW]; p_wa = nx_q[SW-1:0]; p_wd = {1'b0, idx_q};
				end
				S_AFIN: begin
					h_we = 1'b1; h_wa = idx_q;
					h_wd = {2'b10, 5'(want_q) + 5'(MinOrder)};
				end
				S_FCHK: h_ra = off_w[MinOrder +: SW];
				S_FBUD: begin
					h_ra = idx_q ^ bit_l;
					// merged block will head its list, so its prev is none
					p_we = 1'b1; p_wa = idx_q; p_wd = NONE;
				end
				S_FBUDW: begin
					n_ra = bud_q; p_ra = bud_q;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			clr_q     <= 1'b1;
			clr_cnt_q <= '0;
			done_q    <= 1'b0;
			for (int i = 0; i < NOR; i++) head_q[i] <= (i == NOR - 1) ? LW'(0) : NONE;
		end else begin
			done_q <= 1'b0;
			if (clr_q) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
				if (clr_cnt_q == LW'(NS - 1)) clr_q <= 1'b0;
			end else begin
				case (state_q)
					S_IDLE: if (start) begin
						kind_q  <= kind;
						total_q <= {1'b0, request_size} + 33'(HeaderBytes);
						fa_q    <= free_address;
						want_q  <= '0;
						addr_q  <= '0;
						if (kind == KIND_ALLOC) begin
							if (request_size == '0) begin
								st_q <= ST_ZERO; state_q <= S_DONE;
							end else state_q <= S_ASIZE;
						end else begin
							if (free_address == '0) begin
								st_q <= ST_NULL; state_q <= S_DONE;
							end else state_q <= S_FCHK;
						end
					end
					S_ASIZE: begin
						// one order per cycle
						if (total_q > HEAPB) begin
							st_q <= ST_OOM; state_q <= S_DONE;
						end else if ((33'd1 << (5'(want_q) + 5'(MinOrder))) >= total_q
							|| want_q == OW'(SW)) begin
							lvl_q <= want_q; state_q <= S_ASCAN;
						end else want_q <= want_q + 1'b1;
					end
					S_ASCAN: begin
						if (!head_q[lvl_q][SW]) begin
							idx_q <= head_q[lvl_q][SW-1:0]; state_q <= S_AUNL;
						end else if (lvl_q == OW'(SW)) begin
							st_q <= ST_OOM; state_q <= S_DONE;
						end else lvl_q <= lvl_q + 1'b1;
					end
					S_AUNL: state_q <= S_FUNL2;
					S_FUNL2: begin
						// read data from S_AUNL / S_FBUDW now valid
						nx_q <= n_rd; pv_q <= p_rd;
						if (p_rd[SW]) head_q[lvl_q] <= n_rd;
						state_q <= kind_q ? S_FUNL : S_AUNL2;
					end
					S_AUNL2: state_q <= (lvl_q == want_q) ? S_AFIN : S_ASPLIT;
					S_ASPLIT: begin
						lvl_q <= lvl_q - 1'b1;
						nx_q  <= head_q[lvl_q - 1'b1];
						state_q <= S_APUSH;
					end
					S_APUSH: begin
						head_q[lvl_q] <= {1'b0, idx_q | bit_l};
						state_q <= (lvl_q == want_q) ? S_AFIN : S_ASPLIT;
					end
					S_AFIN: begin
						addr_q <= heap_base_q + 32'({idx_q, MinOrder'(0)})
							+ 32'(HeaderBytes);
						st_q <= ST_OK; state_q <= S_DONE;
					end
					S_FCHK: begin
						if (off_w >= 32'(HEAPB) || off_w[MinOrder-1:0] != '0) begin
							st_q <= ST_BADHDR; state_q <= S_DONE;
						end else begin
							idx_q <= off_w[MinOrder +: SW]; state_q <= S_FHDR;
						end
					end
					S_FHDR: begin
						if (!h_rd[6] || h_rd[4:0] < 5'(MinOrder)
							|| h_rd[4:0] > 5'(MaxOrder)) begin
							st_q <= ST_BADHDR; state_q <= S_DONE;
						end else if (h_rd[5]) begin
							st_q <= ST_DOUBLE; state_q <= S_DONE;
						end else begin
							lvl_q <= OW'(h_rd[4:0] - 5'(MinOrder));
							state_q <= S_FBUD;
						end
					end
					S_FBUD: begin
						if (lvl_q == OW'(SW)) begin
							nx_q <= head_q[lvl_q]; state_q <= S_FPUSH;
						end else begin
							bud_q <= idx_q ^ bit_l; state_q <= S_FBUDW;
						end
					end
					S_FBUDW: begin
						if (!h_rd[6] || !h_rd[5]
							|| h_rd[4:0] != 5'(lvl_q) + 5'(MinOrder)) begin
							nx_q <= head_q[lvl_q]; state_q <= S_FPUSH;
						end else state_q <= S_FUNL2;
					end
					S_FUNL: begin
						// unlink writes happen here too
						if (bud_q < idx_q) idx_q <= bud_q;
						lvl_q <= lvl_q + 1'b1;
						state_q <= S_FBUD;
					end
					S_FPUSH: begin
						head_q[lvl_q] <= {1'b0, idx_q};
						st_q <= ST_OK; state_q <= S_DONE;
					end
					S_DONE: begin
						done_q <= 1'b1; state_q <= S_IDLE;
					end
					default: state_q <= S_IDLE;
				endcase
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) done |-> !busy)
		else $error("result while busy");
	assert property (@(posedge clk) disable iff (!arst_n)
		done && status != ST_OK |-> block_address == '0)
		else $error("address on failure");
	assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("request not taken");
endmodule
